[sv/lehmer_keystream_char_rotate_cipher_top_assert.svh]
// Assertion macros shared by the cipher's checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef LEHMER_KEYSTREAM_CHAR_ROTATE_CIPHER_TOP_ASSERT_SVH
`define LEHMER_KEYSTREAM_CHAR_ROTATE_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define LKCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkcr assertion failed");

// Next-cycle implication, disabled while in reset
`define LKCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkcr assertion failed");

`endif

[sv/lkcr_pkg.sv]
// Package for the Lehmer keystream rotation cipher: types, constants,
// generator step, seed repair and mod-96 helpers. No dependencies.
package lkcr_pkg;

  localparam int unsigned GEN_W      = 17;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [6:0]       GEN_MULT    = 7'd75;
  localparam logic [GEN_W-1:0] GEN_MODULUS = 17'd65537;
  localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0]       PRINT_SPAN  = 8'd96;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd1;

  // Configuration write, shared by front and back
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } lkcr_cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              printable;
    logic [GEN_W-1:0]  gen;
  } lkcr_item_t;

  // Bring a written seed into 1..65536
  function automatic logic [GEN_W-1:0] legal_seed(logic [GEN_W-1:0] v);
    logic [GEN_W-1:0] r;
    r = v;
    if (r >= GEN_MODULUS) begin
      r = r - GEN_MODULUS;
    end
    if (r == '0) begin
      r = 17'd1;
    end
    return r;
  endfunction

  // One generator step: g*75 mod 65537 by folding the high half
  function automatic logic [GEN_W-1:0] gen_advance(logic [GEN_W-1:0] g);
    logic [22:0] prod;
    logic [15:0] lo;
    logic [6:0]  hi;
    logic [GEN_W-1:0] nx;
    prod = 23'(g) * 23'(GEN_MULT);
    lo   = prod[15:0];
    hi   = prod[22:16];
    if (17'(lo) >= 17'(hi)) begin
      nx = 17'(lo) - 17'(hi);
    end else begin
      nx = 17'(lo) + GEN_MODULUS - 17'(hi);
    end
    return nx;
  endfunction

  // v mod 96 = 32*((v>>5) mod 3) + v[4:0]; mod 3 by summing base-4 digits
  function automatic logic [6:0] mod96(logic [GEN_W-1:0] v);
    logic [11:0] h;
    logic [4:0]  s;
    logic [2:0]  t;
    h = v[16:5];
    s = '0;
    for (int i = 0; i < 6; i++) begin
      s = s + 5'(h[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return {t[1:0], v[4:0]};
  endfunction

endpackage

[sv/lkcr_front.sv]
// Front end: holds the generator, advances it per accepted byte and
// classifies the byte. Depends on lkcr_pkg.
module lkcr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lkcr_pkg::lkcr_cfg_t          cfg_i,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [lkcr_pkg::BYTE_W-1:0]  in_byte_i,
  output logic                         wr_o,
  output lkcr_pkg::lkcr_item_t         item_o
);
  import lkcr_pkg::*;

  logic [GEN_W-1:0] gen_q, gen_d;
  logic [GEN_W-1:0] gen_next;
  logic             accept;

  assign accept   = push_i && !full_i;
  assign gen_next = gen_advance(gen_q);

  // Seed write reloads; each accepted byte steps the generator
  always_comb begin
    gen_d = gen_q;
    if (cfg_i.we && cfg_i.idx == REG_KEY_SEED) begin
      gen_d = legal_seed(cfg_i.wdata[GEN_W-1:0]);
    end else if (accept) begin
      gen_d = gen_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= 17'd1;
    end else begin
      gen_q <= gen_d;
    end
  end

  // Classify: printable is 32..127
  assign wr_o             = accept;
  assign item_o.data      = in_byte_i;
  assign item_o.printable = !in_byte_i[7] && (in_byte_i[6:5] != 2'b00);
  assign item_o.gen       = gen_next;

endmodule

[sv/lkcr_queue.sv]
// Short FIFO between front and back ends.
// Depends on lkcr_pkg for the item type.
module lkcr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  lkcr_pkg::lkcr_item_t  wr_data_i,
  output logic                  full_o,
  input  logic                  rd_i,
  output logic                  valid_o,
  output lkcr_pkg::lkcr_item_t  rd_data_o
);
  import lkcr_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  lkcr_item_t        mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[sv/lkcr_back.sv]
// Back end: key byte from the generator value, rotation within the
// printable range, and the result register. Depends on lkcr_pkg.
module lkcr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lkcr_pkg::lkcr_cfg_t          cfg_i,
  input  logic                         q_valid_i,
  input  lkcr_pkg::lkcr_item_t         q_item_i,
  output logic                         q_rd_o,
  input  logic                         pop,
  output logic                         empty,
  output logic [lkcr_pkg::BYTE_W-1:0]  out_byte_o
);
  import lkcr_pkg::*;

  logic              mode_q, mode_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              take;
  logic [6:0]        key;
  logic [6:0]        off;
  logic [7:0]        addend;
  logic [7:0]        sum;
  logic [7:0]        wrapped;

  // Mode register
  always_comb begin
    mode_d = mode_q;
    if (cfg_i.we && cfg_i.idx == REG_DECRYPT_MODE) begin
      mode_d = cfg_i.wdata[0];
    end
  end

  // Pull from the queue when the result slot is free or draining
  assign take   = q_valid_i && (!out_valid_q || pop);
  assign q_rd_o = take;

  // Rotate: forward by key, or backward as forward by 96 - key
  always_comb begin
    key     = mod96(q_item_i.gen);
    off     = 7'(q_item_i.data - PRINT_LOW);
    addend  = mode_q ? (PRINT_SPAN - 8'(key)) : 8'(key);
    sum     = 8'(off) + addend;
    wrapped = (sum >= PRINT_SPAN) ? (sum - PRINT_SPAN) : sum;
    out_byte_d = q_item_i.printable ? (wrapped + PRINT_LOW) : q_item_i.data;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= out_byte_d;
    end
  end

  assign empty      = !out_valid_q;
  assign out_byte_o = out_byte_q;

endmodule

[sv/lehmer_keystream_char_rotate_cipher_top.sv]
// Top level of the Lehmer keystream rotation cipher.
// Depends on lkcr_pkg, lkcr_front, lkcr_queue and lkcr_back.
//
// Byte-stream cipher, one byte per clock sustained while pop keeps up. Each
// pushed byte steps a modulo-65537 generator (times 75) and a byte in
// 32..127 is rotated within that range by the new generator value mod 96,
// forward when decrypt_mode is 0 and backward when it is 1; other bytes
// pass through but still step the generator. The rate is set by the
// generator's multiply-and-fold loop in the front end. The front and back
// ends are joined by a QUEUE_DEPTH-entry FIFO and the back end has one
// result register; a pushed byte passes both, in that order, before it
// shows at the result side, and up to QUEUE_DEPTH + 1 bytes are held before
// full rises. Writing key_seed (index 0) reloads the generator, with 0 and
// values above 65536 folded into 1..65536; other indexes than 0 and 1 are
// ignored. Configure only while no bytes are in flight.
module lehmer_keystream_char_rotate_cipher_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lkcr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lkcr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  logic [lkcr_pkg::BYTE_W-1:0]      in_byte_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [lkcr_pkg::BYTE_W-1:0]      out_byte_o
);
  import lkcr_pkg::*;

  lkcr_cfg_t  cfg;
  lkcr_item_t wr_item;
  lkcr_item_t rd_item;
  logic       wr;
  logic       q_full;
  logic       q_valid;
  logic       q_rd;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;
  assign full      = q_full;

  // Generator and classification
  lkcr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .push_i    (push),
    .full_i    (q_full),
    .in_byte_i (in_byte_i),
    .wr_o      (wr),
    .item_o    (wr_item)
  );

  // Decoupling FIFO
  lkcr_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_data_i (wr_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (rd_item)
  );

  // Rotation and result register
  lkcr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_item_i   (rd_item),
    .q_rd_o     (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_byte_o (out_byte_o)
  );

endmodule

[sv/lkcr_checker.sv]
// Port-level checker for the cipher top, attached by bind.
// Depends on the assertion macro header and lkcr_pkg.
`include "lehmer_keystream_char_rotate_cipher_top_assert.svh"

module lkcr_checker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            push,
  input logic                            full,
  input logic                            pop,
  input logic                            empty,
  input logic [lkcr_pkg::BYTE_W-1:0]     out_byte_o
);
  import lkcr_pkg::*;

  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 3);

  logic [OccW-1:0] occ_q, occ_d;
  logic            in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // Bytes accepted but not yet delivered
  always_comb begin
    occ_d = occ_q;
    if (in_xfer && !out_xfer) begin
      occ_d = occ_q + 1'b1;
    end else if (!in_xfer && out_xfer) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `LKCR_ASSERT_NOW(a_no_invented_result, occ_q == '0, empty)
  `LKCR_ASSERT_NOW(a_capacity, 1'b1, occ_q <= OccW'(QUEUE_DEPTH + 1))
  `LKCR_ASSERT_NEXT(a_idle_latency, in_xfer && occ_q == '0, ##1 !empty)
  `LKCR_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_byte_o))

endmodule

bind lehmer_keystream_char_rotate_cipher_top lkcr_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lkcr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .out_byte_o (out_byte_o)
);
